/* hdl/hrm_dps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dps_pkg
// Types, constants and the background rotation function shared by the
// heart-rate data page scheduler.
// ----------------------------------------------------------------------------
package hrm_dps_pkg;

  // Data page numbers
  typedef enum logic [2:0] {
    PG_DEFAULT = 3'd0,
    PG_OPTIME  = 3'd1,
    PG_MFR     = 3'd2,
    PG_PRODUCT = 3'd3,
    PG_PREV    = 3'd4,
    PG_SWIM    = 3'd5,
    PG_CAPS    = 3'd6,
    PG_BATTERY = 3'd7
  } page_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SWIM_MODE      = 3'd0,
    CFG_HAS_PREV_BEAT  = 3'd1,
    CFG_HAS_OPTIME     = 3'd2,
    CFG_HAS_BATTERY    = 3'd3,
    CFG_EXT_FEATURES   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned StepW     = 7;
  localparam int unsigned ToggleW   = 3;
  localparam int unsigned ReqPageW  = 8;

  // Pattern: primary slots first, background slots up to the last step
  localparam logic [StepW-1:0] PRIMARY_SLOTS = 7'd64;
  localparam logic [StepW-1:0] PATTERN_LAST  = 7'd67;

  typedef struct packed {
    logic swim_mode;
    logic has_previous_beat;
    logic has_operating_time;
    logic has_battery;
    logic extended_features;
  } cfg_t;

  typedef struct packed {
    page_e page_number;
    logic  toggle_bit;
  } res_t;

  // Next background page in the ordered rotation, skipping disabled pages
  function automatic page_e rotate_from(page_e cur, cfg_t cfg);
    page_e nxt;
    if (cur < PG_OPTIME && cfg.has_operating_time) begin
      nxt = PG_OPTIME;
    end else if (cur < PG_MFR) begin
      nxt = PG_MFR;
    end else if (cur < PG_PRODUCT) begin
      nxt = PG_PRODUCT;
    end else if (cur < PG_CAPS && cfg.extended_features) begin
      nxt = PG_CAPS;
    end else if (cur < PG_BATTERY && cfg.has_battery) begin
      nxt = PG_BATTERY;
    end else begin
      nxt = cfg.has_operating_time ? PG_OPTIME : PG_MFR;
    end
    return nxt;
  endfunction

endpackage

/* hdl/hrm_dps_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dps_if
// Valid/ready channels of the scheduler: slot words in, page words out and
// configuration writes.
// ----------------------------------------------------------------------------
interface hrm_dps_in_if;
  logic       valid;
  logic       ready;
  logic       request_pending;
  logic [7:0] requested_page;

  modport source (output valid, output request_pending, output requested_page,
                  input ready);
  modport sink   (input valid, input request_pending, input requested_page,
                  output ready);
endinterface

interface hrm_dps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] page_number;
  logic       toggle_bit;

  modport source (output valid, output page_number, output toggle_bit,
                  input ready);
  modport sink   (input valid, input page_number, input toggle_bit,
                  output ready);
endinterface

interface hrm_dps_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/hrm_dps_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dps_cfg
// Configuration register file: one enable bit per register, written by index.
// ----------------------------------------------------------------------------
module hrm_dps_cfg
  import hrm_dps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic               wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_SWIM_MODE:     cfg_d.swim_mode          = wr_data_i;
        CFG_HAS_PREV_BEAT: cfg_d.has_previous_beat  = wr_data_i;
        CFG_HAS_OPTIME:    cfg_d.has_operating_time = wr_data_i;
        CFG_HAS_BATTERY:   cfg_d.has_battery        = wr_data_i;
        CFG_EXT_FEATURES:  cfg_d.extended_features  = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/hrm_dps_sched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dps_sched
// Slot decision: picks the page for one accepted slot word, keeps the pattern
// position, the toggle count and the current background page.
// ----------------------------------------------------------------------------
module hrm_dps_sched
  import hrm_dps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                request_pending_i,
  input  logic [ReqPageW-1:0] requested_page_i,
  input  cfg_t                cfg_i,
  output logic                emit_o,
  output res_t                res_o
);

  logic [StepW-1:0]   pattern_step_q, pattern_step_d;
  logic [ToggleW-1:0] toggle_count_q, toggle_count_d;
  page_e              next_bg_q, next_bg_d;
  logic               req_known;
  logic               emit;
  page_e              primary_page;
  page_e              page;

  // Requests beyond the battery page are dropped without effect
  assign req_known = (requested_page_i[ReqPageW-1:3] == '0);
  assign emit      = !request_pending_i || req_known;

  // Primary page by mode
  always_comb begin
    if (cfg_i.swim_mode) begin
      primary_page = PG_SWIM;
    end else if (cfg_i.has_previous_beat) begin
      primary_page = PG_PREV;
    end else begin
      primary_page = PG_DEFAULT;
    end
  end

  // Pick the page for this slot
  always_comb begin
    if (request_pending_i) begin
      page = page_e'(requested_page_i[2:0]);
    end else if (pattern_step_q < PRIMARY_SLOTS) begin
      page = primary_page;
    end else begin
      page = next_bg_q;
    end
  end

  assign emit_o            = accept_i && emit;
  assign res_o.page_number = page;
  assign res_o.toggle_bit  = toggle_count_q[ToggleW-1];

  // Advance state on every sent word; requests leave the pattern alone
  always_comb begin
    pattern_step_d = pattern_step_q;
    toggle_count_d = toggle_count_q;
    next_bg_d      = next_bg_q;
    if (accept_i && emit) begin
      toggle_count_d = ToggleW'(toggle_count_q + 1'b1);
      if (!request_pending_i) begin
        if (pattern_step_q >= PATTERN_LAST) begin
          pattern_step_d = '0;
          next_bg_d      = rotate_from(next_bg_q, cfg_i);
        end else begin
          pattern_step_d = StepW'(pattern_step_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_step_q <= '0;
      toggle_count_q <= '0;
      next_bg_q      <= PG_MFR;
    end else begin
      pattern_step_q <= pattern_step_d;
      toggle_count_q <= toggle_count_d;
      next_bg_q      <= next_bg_d;
    end
  end

  // Pattern never runs past its last background slot
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pattern_step_q <= PATTERN_LAST)
    else $error("pattern step beyond last slot");

  // Background page is always one of the rotation pages
  a_bg_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_bg_q == PG_OPTIME || next_bg_q == PG_MFR || next_bg_q == PG_PRODUCT ||
    next_bg_q == PG_CAPS || next_bg_q == PG_BATTERY)
    else $error("background page outside rotation");

  // Every sent word advances the toggle count by one
  a_toggle_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |=> toggle_count_q == ToggleW'($past(toggle_count_q) + 1'b1))
    else $error("toggle count did not advance");

  // A dropped request leaves the pattern and the toggle count untouched
  a_drop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !emit) |=> $stable(pattern_step_q) && $stable(toggle_count_q))
    else $error("dropped request changed state");

endmodule

/* hdl/hrm_dps_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_dps_out_reg
// Result register: holds one page word for the receiver and frees itself
// in the same cycle the word is taken.
// ----------------------------------------------------------------------------
module hrm_dps_out_reg
  import hrm_dps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_ready_i,
  output logic free_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Slot free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: load only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/hrm_data_page_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_data_page_scheduler_top
// Heart-rate monitor data page scheduler.
// ----------------------------------------------------------------------------
// Each word on in_i is one transmit slot: a request flag and a requested page.
// The block answers with at most one word on out_o: the page number to send
// and its page-change toggle bit. A request for a page above 7 is taken and
// dropped; no word comes out and no state moves.
// cfg_i writes one enable bit by index; it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// Latency: a page word is valid on out_o the cycle after its slot word is
// accepted. Throughput: one slot word per cycle while the receiver takes each
// word, set by the single result register, which is refilled in the cycle its word is taken.
// When the receiver stalls, the result register holds its word and in_i
// ready drops until it drains.
// Reset clears the enables, the pattern position and the toggle count and
// sets the background page to manufacturer information; the block is ready
// in the first cycle after reset.
// ----------------------------------------------------------------------------
module hrm_data_page_scheduler_top
  import hrm_dps_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  hrm_dps_in_if.sink     in_i,
  hrm_dps_out_if.source  out_o,
  hrm_dps_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  logic free;
  logic accept;
  logic emit;
  res_t res;
  res_t res_out;

  // Configuration channel
  assign cfg_i.ready = 1'b1;

  hrm_dps_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // Accept a slot whenever the result register can take its word
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  hrm_dps_sched u_sched (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .request_pending_i (in_i.request_pending),
    .requested_page_i  (in_i.requested_page),
    .cfg_i             (cfg),
    .emit_o            (emit),
    .res_o             (res)
  );

  hrm_dps_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .free_o      (free),
    .out_valid_o (out_o.valid),
    .res_o       (res_out)
  );

  assign out_o.page_number = res_out.page_number;
  assign out_o.toggle_bit  = res_out.toggle_bit;

endmodule
